// ----- src/sdiv_pkg.sv -----
// shared types and constants for the signed truncating divider
// no dependencies; used by sdiv_core, signed_truncating_divider_top and the verif checker and test

package sdiv_pkg;

	localparam int DATA_W = 32;
	localparam int DIVR_W = DATA_W - 1;
	localparam int CNT_W  = $clog2(DATA_W);

	typedef struct packed {
		logic signed [DATA_W-1:0] dividend;
		logic        [DIVR_W-1:0] divisor;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] quotient;
		logic signed [DATA_W-1:0] remainder;
		logic                     divide_error;
	} rsp_t;

	typedef struct packed {
		logic busy;
		logic last;
	} core_stat_t;

endpackage

// ----- src/signed_truncating_divider_top.sv -----
// signed truncating divider top level: handshake, sign handling, result register
// depends on sdiv_pkg and sdiv_core

// Divides a signed 32-bit dividend by a 31-bit non-negative divisor and returns the
// quotient truncated toward zero and a remainder with the sign of the dividend.
// A zero divisor sets divide_error and returns zero quotient and remainder. The
// magnitude of the dividend is taken as the transaction is accepted. The result
// register is loaded from the fix state once the restoring divider, which resolves one
// quotient bit per cycle, has worked through all 32 dividend bits; the signs are restored
// as it loads. One transaction is in the divider at a time, and req_stall is high while it works.
// The next transaction can be accepted in the cycle after the result register loads. A
// finished result waits in the output register while the next transaction is accepted.
// If the previous result is not yet taken, the divider holds its result and req_stall
// stays high until it moves.

module signed_truncating_divider_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sdiv_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output sdiv_pkg::rsp_t  rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIX
	} state_t;

	state_t state_q;
	logic   neg_q;
	logic   err_q;
	logic   rsp_valid_q;
	sdiv_pkg::rsp_t rsp_q;

	logic                        accept;
	logic                        dvd_neg;
	logic [sdiv_pkg::DATA_W-1:0] magnitude;
	logic [sdiv_pkg::DATA_W-1:0] quo;
	logic [sdiv_pkg::DIVR_W-1:0] rem;
	logic [sdiv_pkg::DATA_W-1:0] rem_ext;
	logic                        out_free;
	sdiv_pkg::core_stat_t        stat;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign dvd_neg   = req.dividend[sdiv_pkg::DATA_W-1];
	assign magnitude = dvd_neg ? (~req.dividend + 1'b1) : req.dividend;
	assign rem_ext   = {1'b0, rem};
	assign out_free  = !rsp_valid_q || !rsp_stall;

	sdiv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.magnitude (magnitude),
		.divisor   (req.divisor),
		.quo       (quo),
		.rem       (rem),
		.stat      (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			neg_q       <= 1'b0;
			err_q       <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// a result leaving while the next one loads keeps valid high
			if (rsp_valid_q && !rsp_stall && state_q != ST_FIX) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q   <= dvd_neg;
						err_q   <= (req.divisor == '0);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (stat.last) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					// hold the result until the output register is free
					if (out_free) begin
						if (err_q) begin
							rsp_q.quotient  <= '0;
							rsp_q.remainder <= '0;
						end else begin
							rsp_q.quotient  <= neg_q ? (~quo + 1'b1) : quo;
							rsp_q.remainder <= neg_q ? (~rem_ext + 1'b1) : rem_ext;
						end
						rsp_q.divide_error <= err_q;
						rsp_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// only one transaction in the divider at a time
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> stat.busy && req_stall)
		else $error("transaction accepted while divider busy");

	// the divider finishes only while the control expects it
	a_last_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		stat.last |-> (state_q == ST_RUN))
		else $error("divider finished outside run state");

	// a zero divisor gives zero quotient and remainder
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.divide_error |-> (rsp.quotient == '0) && (rsp.remainder == '0))
		else $error("nonzero result with divide error");

	// a result is not overwritten while it waits to be taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("pending result overwritten");

endmodule

// ----- src/sdiv_core.sv -----
// restoring divider datapath: one quotient bit per cycle through shift registers
// depends on sdiv_pkg

module sdiv_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [sdiv_pkg::DATA_W-1:0]     magnitude,
	input  logic [sdiv_pkg::DIVR_W-1:0]     divisor,
	output logic [sdiv_pkg::DATA_W-1:0]     quo,
	output logic [sdiv_pkg::DIVR_W-1:0]     rem,
	output sdiv_pkg::core_stat_t            stat
);

	logic [sdiv_pkg::DATA_W-1:0] quo_q;
	logic [sdiv_pkg::DIVR_W-1:0] rem_q;
	logic [sdiv_pkg::DIVR_W-1:0] divr_q;
	logic [sdiv_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;

	logic [sdiv_pkg::DATA_W-1:0] shifted;
	logic [sdiv_pkg::DATA_W:0]   diff;
	logic                        ge;
	logic                        last;

	// partial remainder stays below the divisor, so it fits in DIVR_W bits
	assign shifted = {rem_q, quo_q[sdiv_pkg::DATA_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divr_q};
	assign ge      = ~diff[sdiv_pkg::DATA_W];
	assign last    = busy_q && (cnt_q == sdiv_pkg::CNT_W'(sdiv_pkg::DATA_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= magnitude;
			rem_q  <= '0;
			divr_q <= divisor;
		end else if (busy_q) begin
			// dividend bits leave at the top while quotient bits enter at the bottom
			quo_q <= {quo_q[sdiv_pkg::DATA_W-2:0], ge};
			rem_q <= ge ? diff[sdiv_pkg::DIVR_W-1:0] : shifted[sdiv_pkg::DIVR_W-1:0];
		end
	end

	assign quo       = quo_q;
	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.last = last;

endmodule

// ----- verif/signed_truncating_divider_checker.sv -----
`timescale 1ns / 100ps
// result checker for the signed truncating divider: predicts each division and compares
// depends on sdiv_pkg; instantiated by signed_truncating_divider_top_test

module signed_truncating_divider_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  sdiv_pkg::req_t   req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  sdiv_pkg::rsp_t   rsp,
	output int unsigned      fail_count,
	output int unsigned      outstanding,
	output int unsigned      checked_count,
	output int unsigned      zero_divisor_count
);

	sdiv_pkg::rsp_t quotients_due[$];

	// truncate toward zero, remainder follows the sign of the dividend
	function automatic sdiv_pkg::rsp_t divide_toward_zero(input sdiv_pkg::req_t item);
		sdiv_pkg::rsp_t              res;
		logic                        neg;
		logic [sdiv_pkg::DATA_W-1:0] mag;
		logic [sdiv_pkg::DATA_W-1:0] den;
		logic [sdiv_pkg::DATA_W-1:0] q;
		logic [sdiv_pkg::DATA_W-1:0] r;
		res = '0;
		if (item.divisor == '0) begin
			res.divide_error = 1'b1;
			return res;
		end
		neg = item.dividend[sdiv_pkg::DATA_W-1];
		mag = neg ? ~$unsigned(item.dividend) + 1'b1 : $unsigned(item.dividend);
		den = {1'b0, item.divisor};
		q = mag / den;
		r = mag % den;
		if (neg) begin
			q = ~q + 1'b1;
			r = ~r + 1'b1;
		end
		res.quotient  = q;
		res.remainder = r;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sdiv_pkg::rsp_t want;
		int             bad;
		if (!arst_n) begin
			quotients_due.delete();
			fail_count         <= 0;
			outstanding        <= 0;
			checked_count      <= 0;
			zero_divisor_count <= 0;
		end else begin
			bad = 0;
			// pop before push so a stray result never matches a transaction taken this cycle
			if (rsp_valid && !rsp_stall) begin
				if (quotients_due.size() == 0) begin
					$error("result with no transaction waiting: q %0d r %0d err %0b",
						rsp.quotient, rsp.remainder, rsp.divide_error);
					bad++;
				end else begin
					want = quotients_due.pop_front();
					if (rsp.quotient !== want.quotient) begin
						$error("quotient: expected %0d, actual %0d", want.quotient,
							rsp.quotient);
						bad++;
					end
					if (rsp.remainder !== want.remainder) begin
						$error("remainder: expected %0d, actual %0d", want.remainder,
							rsp.remainder);
						bad++;
					end
					if (rsp.divide_error !== want.divide_error) begin
						$error("divide_error: expected %0b, actual %0b", want.divide_error,
							rsp.divide_error);
						bad++;
					end
					checked_count <= checked_count + 1;
					if (want.divide_error)
						zero_divisor_count <= zero_divisor_count + 1;
				end
			end
			if (req_valid && !req_stall)
				quotients_due.push_back(divide_toward_zero(req));
			fail_count  <= fail_count + bad;
			outstanding <= quotients_due.size();
		end
	end

endmodule

// ----- verif/signed_truncating_divider_top_test.sv -----
`timescale 1ns / 100ps
// testbench top for the signed truncating divider: clock, reset, stimulus and verdict
// depends on sdiv_pkg, signed_truncating_divider_top and signed_truncating_divider_checker

module signed_truncating_divider_top_test;

	localparam int          RANDOM_ITEMS = 1630;
	localparam int          CALM_TAIL    = 200;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam logic signed [sdiv_pkg::DATA_W-1:0] DIVIDEND_MAX =
		{1'b0, {(sdiv_pkg::DATA_W-1){1'b1}}};
	localparam logic signed [sdiv_pkg::DATA_W-1:0] DIVIDEND_MIN =
		{1'b1, {(sdiv_pkg::DATA_W-1){1'b0}}};
	localparam int          DIVISOR_MAX  = int'({1'b0, {sdiv_pkg::DIVR_W{1'b1}}});

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	sdiv_pkg::req_t req       = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	sdiv_pkg::rsp_t rsp;

	logic        rsp_idle_on = 1'b1;
	bit          req_gaps_on = 1'b1;
	int unsigned stall_left  = 0;
	int unsigned cycle_count = 0;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned checked_count;
	int unsigned zero_divisor_count;

	signed_truncating_divider_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	signed_truncating_divider_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.req_valid          (req_valid),
		.req_stall          (req_stall),
		.req                (req),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.rsp                (rsp),
		.fail_count         (fail_count),
		.outstanding        (outstanding),
		.checked_count      (checked_count),
		.zero_divisor_count (zero_divisor_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d transactions still open", cycle_count,
			outstanding);
		$display("CHECK FAILED");
		$finish;
	end

	// result side backpressure in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall  <= 1'b0;
			stall_left <= 0;
		end else if (!rsp_idle_on) begin
			rsp_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_division(input int num, input int den);
		sdiv_pkg::req_t item;
		item.dividend = sdiv_pkg::DATA_W'(num);
		item.divisor  = sdiv_pkg::DIVR_W'(den);
		if (req_gaps_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		logic signed [sdiv_pkg::DATA_W-1:0] num;
		logic        [sdiv_pkg::DIVR_W-1:0] den;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: extremes, zero divisor, zero dividend, exact and near multiples
		send_division(0, 1);
		send_division(0, 0);
		send_division(DIVIDEND_MAX, 1);
		send_division(DIVIDEND_MIN, 1);
		send_division(DIVIDEND_MIN, DIVISOR_MAX);
		send_division(DIVIDEND_MAX, DIVISOR_MAX);
		send_division(-1, 1);
		send_division(-1, DIVISOR_MAX);
		send_division(1, DIVISOR_MAX);
		send_division(DIVIDEND_MIN, 2);
		send_division(DIVIDEND_MIN, 3);
		send_division(7, 2);
		send_division(-7, 2);
		send_division(7, 0);
		send_division(DIVIDEND_MIN, 0);
		send_division(DIVIDEND_MAX, 0);
		send_division(-1, 0);
		send_division(100, 100);
		send_division(-100, 100);
		send_division(99, 100);
		send_division(-99, 100);
		send_division(5, 7);
		send_division(-5, 7);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				drain_results();
			if (i >= RANDOM_ITEMS - CALM_TAIL) begin
				req_gaps_on = 1'b0;
				rsp_idle_on <= 1'b0;
			end else if (i % 150 == 0) begin
				req_gaps_on = ($urandom_range(0, 3) != 0);
				rsp_idle_on <= ($urandom_range(0, 3) != 0);
			end

			// operands of random bit length so small and large quotients both show up
			num = $urandom;
			num = $unsigned(num) >> $urandom_range(0, sdiv_pkg::DATA_W - 1);
			if ($urandom_range(0, 1))
				num = -num;
			den = sdiv_pkg::DIVR_W'($urandom);
			den = den >> $urandom_range(0, sdiv_pkg::DIVR_W - 1);
			case ($urandom_range(0, 19))
				0: den = '0;
				1: num = DIVIDEND_MIN;
				2: num = DIVIDEND_MAX;
				3: num = $urandom;
				default: ;
			endcase
			send_division(num, int'(den));
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (40) @(posedge clk);

		$display("%0d divisions checked, %0d of them by zero, over %0d cycles",
			checked_count, zero_divisor_count, cycle_count);
		$display("random operand lengths, sign extremes and handshake stalls on both sides");
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
